>>> src/cti_pkg.sv
// shared constants, codes and beat types of the calibrated table interpolator
package cti_pkg;

   localparam int MAX_BINS = 16;
   localparam int TAB_AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int BIN_CW   = $clog2(MAX_BINS + 1);
   localparam int FRAC_W   = 16;
   localparam int DVD_W    = 64;
   localparam int DVS_W    = 33;
   localparam int QUO_W    = 32;

   localparam logic signed [31:0] Q_ONE       = 32'sh0001_0000;
   localparam logic signed [31:0] Q_MINUS_ONE = 32'shFFFF_0000;
   localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;

   localparam logic FUNC_QUERY = 1'b0;
   localparam logic FUNC_LOAD  = 1'b1;

   localparam logic [2:0] ST_INTERP    = 3'd0;
   localparam logic [2:0] ST_BEYOND    = 3'd1;
   localparam logic [2:0] ST_NO_TABLE  = 3'd2;
   localparam logic [2:0] ST_ZERO_WIDE = 3'd3;
   localparam logic [2:0] ST_LOAD_DONE = 3'd4;

   localparam logic [2:0] REG_BIN_COUNT      = 3'd0;
   localparam logic [2:0] REG_CROSS_SECTION  = 3'd1;
   localparam logic [2:0] REG_CAL_GAIN       = 3'd2;
   localparam logic [2:0] REG_CAL_OFFSET     = 3'd3;
   localparam logic [2:0] REG_CAL_REF_GAIN   = 3'd4;
   localparam logic [2:0] REG_CAL_REF_OFFSET = 3'd5;

   typedef struct packed {
      logic              func;
      logic              use_calibration;
      logic signed [31:0] energy;
      logic [3:0]        entry_index;
      logic signed [31:0] entry_edge;
      logic signed [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0]        status;
   } rsp_type;

endpackage

>>> src/cti_div.sv
// serial signed divider, one quotient bit per cycle, saturated 32-bit quotient
module cti_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [cti_pkg::DVD_W-1:0]     dividend,
   input  logic signed [cti_pkg::DVS_W-1:0]     divisor,
   output logic                                 done,
   output logic signed [cti_pkg::QUO_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(cti_pkg::DVD_W);

   logic                         active_ff, active_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         neg_ff, neg_in;
   logic [cti_pkg::DVD_W-1:0]    num_ff, num_in;
   logic [cti_pkg::DVS_W-1:0]    den_ff, den_in;
   logic [cti_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [cti_pkg::DVS_W:0]      rem_sh;
   logic                         fits;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      rem_sh    = {rem_ff, num_ff[cti_pkg::DVD_W-1]};
      fits      = (rem_sh >= {1'b0, den_ff});
      if (start) begin
         active_in = 1'b1;
         count_in  = '0;
         neg_in    = dividend[cti_pkg::DVD_W-1] ^ divisor[cti_pkg::DVS_W-1];
         num_in    = dividend[cti_pkg::DVD_W-1] ? -dividend : dividend;
         den_in    = divisor[cti_pkg::DVS_W-1] ? -divisor : divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         if (fits) begin
            rem_in = cti_pkg::DVS_W'(rem_sh - {1'b0, den_ff});
         end else begin
            rem_in = rem_sh[cti_pkg::DVS_W-1:0];
         end
         num_in   = {num_ff[cti_pkg::DVD_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(cti_pkg::DVD_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (num_ff > cti_pkg::DVD_W'(64'h8000_0000)) begin
            quotient = cti_pkg::S32_MIN;
         end else begin
            quotient = -num_ff[cti_pkg::QUO_W-1:0];
         end
      end else begin
         if (num_ff > cti_pkg::DVD_W'(64'h7FFF_FFFF)) begin
            quotient = cti_pkg::S32_MAX;
         end else begin
            quotient = num_ff[cti_pkg::QUO_W-1:0];
         end
      end
   end

   assign done = done_ff;

endmodule

>>> src/calibrated_table_interpolator_top.sv
// calibrated piecewise linear table interpolator, top level
//
// A request beat is taken when start is high and busy is low. A load beat
// (func set) writes one edge/value pair of the 16-entry table; a query beat
// looks up the energy, optionally calibrated by gain and offset first.
// Every beat gives one response beat: rsp_valid is high for one cycle with
// rsp_payload, and the receiver takes it in that cycle; it cannot stall.
// The user must write registers through the APB port only while the block
// is idle; the block itself does not enforce it. A load or a query on an
// empty table answers in the cycle after the request. An interpolating
// query runs calibration if asked, searches bin by bin, divides for the
// slope, multiplies and answers; one beyond the table or on a zero-width
// bin answers right after the search. The serial divider, one quotient bit
// per cycle, takes most of the time. busy stays high for the whole query,
// so a new request waits for it. Loads can follow each other every cycle.
// Reset clears the table, registers and sequencer at once.
module calibrated_table_interpolator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cti_pkg::req_type   req_payload,
   output logic               rsp_valid,
   output cti_pkg::rsp_type   rsp_payload,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CAL_MUL   = 9'b000000010,
      S_CAL_NUM   = 9'b000000100,
      S_CAL_DIV   = 9'b000001000,
      S_SEARCH    = 9'b000010000,
      S_SLOPE     = 9'b000100000,
      S_SLOPE_DIV = 9'b001000000,
      S_TERM_MUL  = 9'b010000000,
      S_FINISH    = 9'b100000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [4:0]                      bin_count_ff;
   logic signed [31:0]              cross_ff, gain_ff, offset_ff, ref_gain_ff, ref_offset_ff;
   logic signed [31:0]              edge_tab_ff [cti_pkg::MAX_BINS];
   logic signed [31:0]              value_tab_ff [cti_pkg::MAX_BINS];
   logic signed [31:0]              e_ff, e_in;
   logic [cti_pkg::BIN_CW-1:0]      n_ff, n_in;
   logic [cti_pkg::BIN_CW-1:0]      i_ff, i_in;
   logic signed [31:0]              low_ff, low_in, lowe_ff, lowe_in;
   logic signed [31:0]              up_ff, up_in, upe_ff, upe_in;
   logic signed [32:0]              dx_ff, dx_in;
   logic signed [31:0]              slope_ff, slope_in;
   logic signed [65:0]              prod_ff, prod_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cti_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            accept, cfg_wr;
   logic [cti_pkg::BIN_CW-1:0]      n_req;
   logic signed [31:0]              edge_rd, value_rd;
   logic signed [31:0]              aref;
   logic signed [32:0]              de, dv, dx, off_diff;
   logic signed [63:0]              cal_num;
   logic signed [32:0]              mul_a, mul_b;
   logic                            div_start, div_done;
   logic signed [63:0]              div_dividend;
   logic signed [32:0]              div_divisor;
   logic signed [31:0]              div_q;
   logic                            round_up;
   logic signed [49:0]              term;
   logic signed [50:0]              sum;
   logic signed [31:0]              sum_sat;
   logic                            dv_pos, dv_neg, dx_pos, dx_neg;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff  <= '0;
         cross_ff      <= '0;
         gain_ff       <= cti_pkg::Q_ONE;
         offset_ff     <= '0;
         ref_gain_ff   <= cti_pkg::Q_ONE;
         ref_offset_ff <= '0;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            cti_pkg::REG_BIN_COUNT:      bin_count_ff  <= pwdata[4:0];
            cti_pkg::REG_CROSS_SECTION:  cross_ff      <= pwdata;
            cti_pkg::REG_CAL_GAIN:       gain_ff       <= pwdata;
            cti_pkg::REG_CAL_OFFSET:     offset_ff     <= pwdata;
            cti_pkg::REG_CAL_REF_GAIN:   ref_gain_ff   <= pwdata;
            cti_pkg::REG_CAL_REF_OFFSET: ref_offset_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         cti_pkg::REG_BIN_COUNT:      prdata = {27'b0, bin_count_ff};
         cti_pkg::REG_CROSS_SECTION:  prdata = cross_ff;
         cti_pkg::REG_CAL_GAIN:       prdata = gain_ff;
         cti_pkg::REG_CAL_OFFSET:     prdata = offset_ff;
         cti_pkg::REG_CAL_REF_GAIN:   prdata = ref_gain_ff;
         cti_pkg::REG_CAL_REF_OFFSET: prdata = ref_offset_ff;
         default:                     prdata = '0;
      endcase
   end

   // table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < cti_pkg::MAX_BINS; k++) begin
            edge_tab_ff[k]  <= '0;
            value_tab_ff[k] <= '0;
         end
      end else if (accept && req_payload.func == cti_pkg::FUNC_LOAD
                   && 32'(req_payload.entry_index) < 32'(cti_pkg::MAX_BINS)) begin
         edge_tab_ff[cti_pkg::TAB_AW'(req_payload.entry_index)]  <= req_payload.entry_edge;
         value_tab_ff[cti_pkg::TAB_AW'(req_payload.entry_index)] <= req_payload.entry_value;
      end
   end

   always_comb begin
      if (32'(bin_count_ff) > 32'(cti_pkg::MAX_BINS)) begin
         n_req = cti_pkg::BIN_CW'(cti_pkg::MAX_BINS);
      end else begin
         n_req = cti_pkg::BIN_CW'(bin_count_ff);
      end
   end

   assign edge_rd  = edge_tab_ff[i_ff[cti_pkg::TAB_AW-1:0]];
   assign value_rd = value_tab_ff[i_ff[cti_pkg::TAB_AW-1:0]];
   assign aref     = (ref_gain_ff == 0) ? cti_pkg::Q_ONE : ref_gain_ff;
   assign off_diff = {ref_offset_ff[31], ref_offset_ff} - {offset_ff[31], offset_ff};
   assign cal_num  = prod_ff[63:0] - {{15{off_diff[32]}}, off_diff, 16'b0};
   assign de       = {upe_ff[31], upe_ff} - {lowe_ff[31], lowe_ff};
   assign dv       = {up_ff[31], up_ff} - {low_ff[31], low_ff};
   assign dx       = {e_ff[31], e_ff} - {lowe_ff[31], lowe_ff};
   assign dv_pos   = !dv[32] && (dv != 0);
   assign dv_neg   = dv[32];
   assign dx_pos   = !dx[32] && (dx != 0);
   assign dx_neg   = dx[32];

   // shared multiplier
   always_comb begin
      if (state_ff == S_TERM_MUL) begin
         mul_a = {slope_ff[31], slope_ff};
         mul_b = dx_ff;
      end else begin
         mul_a = {gain_ff[31], gain_ff};
         mul_b = {e_ff[31], e_ff};
      end
      prod_in = mul_a * mul_b;
   end

   // shared divider
   assign div_start    = (state_ff == S_CAL_NUM) || ((state_ff == S_SLOPE) && (de != 0));
   assign div_dividend = (state_ff == S_CAL_NUM) ? cal_num
                                                 : {{15{dv[32]}}, dv, 16'b0};
   assign div_divisor  = (state_ff == S_CAL_NUM) ? {aref[31], aref} : de;

   cti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // truncate toward zero, then add the lower value
   assign round_up = prod_ff[65] && (prod_ff[cti_pkg::FRAC_W-1:0] != 0);
   assign term     = prod_ff[65:cti_pkg::FRAC_W] + {49'b0, round_up};
   assign sum      = {{19{low_ff[31]}}, low_ff} + {term[49], term};

   always_comb begin
      if (!sum[50] && (sum[49:31] != '0)) begin
         sum_sat = cti_pkg::S32_MAX;
      end else if (sum[50] && (sum[49:31] != '1)) begin
         sum_sat = cti_pkg::S32_MIN;
      end else begin
         sum_sat = sum[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      low_in       = low_ff;
      lowe_in      = lowe_ff;
      up_in        = up_ff;
      upe_in       = upe_ff;
      dx_in        = dx_ff;
      slope_in     = slope_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               e_in    = req_payload.energy;
               n_in    = n_req;
               i_in    = '0;
               low_in  = '0;
               lowe_in = '0;
               if (req_payload.func == cti_pkg::FUNC_LOAD) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.result_value = '0;
                  rsp_in.status       = cti_pkg::ST_LOAD_DONE;
               end else if (n_req == 0 || edge_tab_ff[0] == 0) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.result_value = cti_pkg::Q_MINUS_ONE;
                  rsp_in.status       = cti_pkg::ST_NO_TABLE;
               end else if (req_payload.use_calibration) begin
                  state_in = S_CAL_MUL;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_CAL_MUL: state_in = S_CAL_NUM;
         S_CAL_NUM: state_in = S_CAL_DIV;
         S_CAL_DIV: begin
            if (div_done) begin
               e_in     = div_q;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (i_ff < n_ff && e_ff > edge_rd) begin
               lowe_in = edge_rd;
               low_in  = value_rd;
               i_in    = i_ff + 1'b1;
            end else if (i_ff >= n_ff || value_rd <= 0) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = cross_ff;
               rsp_in.status       = cti_pkg::ST_BEYOND;
               state_in            = S_IDLE;
            end else begin
               upe_in   = edge_rd;
               up_in    = value_rd;
               state_in = S_SLOPE;
            end
         end
         S_SLOPE: begin
            dx_in = dx;
            if (de == 0) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = cti_pkg::ST_ZERO_WIDE;
               if ((dv_pos && dx_pos) || (dv_neg && dx_neg)) begin
                  rsp_in.result_value = cti_pkg::S32_MAX;
               end else if ((dv_pos && dx_neg) || (dv_neg && dx_pos)) begin
                  rsp_in.result_value = cti_pkg::S32_MIN;
               end else begin
                  rsp_in.result_value = low_ff;
               end
               state_in = S_IDLE;
            end else begin
               state_in = S_SLOPE_DIV;
            end
         end
         S_SLOPE_DIV: begin
            if (div_done) begin
               slope_in = div_q;
               state_in = S_TERM_MUL;
            end
         end
         S_TERM_MUL: state_in = S_FINISH;
         S_FINISH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_value = sum_sat;
            rsp_in.status       = cti_pkg::ST_INTERP;
            state_in            = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      n_ff     <= n_in;
      i_ff     <= i_in;
      low_ff   <= low_in;
      lowe_ff  <= lowe_in;
      up_ff    <= up_in;
      upe_ff   <= upe_in;
      dx_ff    <= dx_in;
      slope_ff <= slope_in;
      rsp_ff   <= rsp_in;
      if (state_ff == S_CAL_MUL || state_ff == S_TERM_MUL) begin
         prod_ff <= prod_in;
      end
   end

endmodule

>>> bench/calibrated_table_interpolator_top_tb.sv
// testbench for the calibrated table interpolator: directed and random beats checked by a predictor
module calibrated_table_interpolator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SPREAD = 1 << 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cti_pkg::req_type req_payload = '0;
   logic rsp_valid;
   cti_pkg::rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   cti_pkg::req_type beats_to_send[$];
   cti_pkg::rsp_type centrality_due[$];
   int sender_idle_pct = 36;
   int mismatches = 0;
   int cycles = 0;

   logic signed [31:0] edge_tab [cti_pkg::MAX_BINS];
   logic signed [31:0] level_tab [cti_pkg::MAX_BINS];
   logic [4:0] bins_in_use;
   logic signed [31:0] cross_section_q;
   logic signed [31:0] cal_gain_q;
   logic signed [31:0] cal_offset_q;
   logic signed [31:0] cal_ref_gain_q;
   logic signed [31:0] cal_ref_offset_q;

   calibrated_table_interpolator_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin : clock_gen
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] q16(int whole);
      return whole <<< cti_pkg::FRAC_W;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > longint'(cti_pkg::S32_MAX)) return longint'(cti_pkg::S32_MAX);
      if (x < longint'(cti_pkg::S32_MIN)) return longint'(cti_pkg::S32_MIN);
      return x;
   endfunction

   function automatic longint calibrated_energy(longint e);
      longint aref;
      longint num;
      aref = (cal_ref_gain_q == 0) ? longint'(cti_pkg::Q_ONE) : longint'(cal_ref_gain_q);
      num = longint'(cal_gain_q) * e
            - (longint'(cal_ref_offset_q) - longint'(cal_offset_q)) * longint'(cti_pkg::Q_ONE);
      return clamp32(num / aref);
   endfunction

   // table update for loads, interpolated centrality for queries
   function automatic cti_pkg::rsp_type centrality_of(cti_pkg::req_type r);
      cti_pkg::rsp_type o;
      longint e, up, low, upe, lowe, dv, de, dx, slope, res;
      int n, i;
      logic pos, neg;
      o.result_value = '0;
      o.status = cti_pkg::ST_LOAD_DONE;
      if (r.func == cti_pkg::FUNC_LOAD) begin
         if (r.entry_index < cti_pkg::MAX_BINS) begin
            edge_tab[r.entry_index] = r.entry_edge;
            level_tab[r.entry_index] = r.entry_value;
         end
         return o;
      end
      n = (bins_in_use > cti_pkg::MAX_BINS) ? cti_pkg::MAX_BINS : int'(bins_in_use);
      if (n == 0 || edge_tab[0] == 0) begin
         o.result_value = cti_pkg::Q_MINUS_ONE;
         o.status = cti_pkg::ST_NO_TABLE;
         return o;
      end
      e = longint'($signed(r.energy));
      if (r.use_calibration) e = calibrated_energy(e);
      i = 0;
      while (i < n && e > longint'(edge_tab[i])) i++;
      if (i >= n || level_tab[i] <= 0) begin
         o.result_value = cross_section_q;
         o.status = cti_pkg::ST_BEYOND;
         return o;
      end
      up = longint'(level_tab[i]);
      upe = longint'(edge_tab[i]);
      low = (i > 0) ? longint'(level_tab[i - 1]) : 0;
      lowe = (i > 0) ? longint'(edge_tab[i - 1]) : 0;
      dv = up - low;
      de = upe - lowe;
      dx = e - lowe;
      if (de == 0) begin
         pos = (dv > 0 && dx > 0) || (dv < 0 && dx < 0);
         neg = (dv > 0 && dx < 0) || (dv < 0 && dx > 0);
         res = pos ? longint'(cti_pkg::S32_MAX) : (neg ? longint'(cti_pkg::S32_MIN) : low);
         o.status = cti_pkg::ST_ZERO_WIDE;
      end else begin
         slope = clamp32((dv * longint'(cti_pkg::Q_ONE)) / de);
         res = clamp32(low + (slope * dx) / longint'(cti_pkg::Q_ONE));
         o.status = cti_pkg::ST_INTERP;
      end
      o.result_value = res[31:0];
      return o;
   endfunction

   function automatic void send_query(logic signed [31:0] e, logic cal);
      cti_pkg::req_type b;
      b.func = cti_pkg::FUNC_QUERY;
      b.use_calibration = cal;
      b.energy = e;
      b.entry_index = 4'($urandom);
      b.entry_edge = $urandom;
      b.entry_value = $urandom;
      beats_to_send.push_back(b);
   endfunction

   function automatic void send_load(logic [3:0] idx, logic signed [31:0] edge_q,
                                     logic signed [31:0] value_q);
      cti_pkg::req_type b;
      b.func = cti_pkg::FUNC_LOAD;
      b.use_calibration = 1'($urandom);
      b.energy = $urandom;
      b.entry_index = idx;
      b.entry_edge = edge_q;
      b.entry_value = value_q;
      beats_to_send.push_back(b);
   endfunction

   task automatic report_mismatch(string what, cti_pkg::rsp_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected value %h status %0d, got value %h status %0d", what,
                  want.result_value, want.status, rsp_payload.result_value, rsp_payload.status);
   endtask

   task automatic wait_idle();
      while (beats_to_send.size() != 0 || centrality_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         cti_pkg::REG_BIN_COUNT: bins_in_use = value[4:0];
         cti_pkg::REG_CROSS_SECTION: cross_section_q = value;
         cti_pkg::REG_CAL_GAIN: cal_gain_q = value;
         cti_pkg::REG_CAL_OFFSET: cal_offset_q = value;
         cti_pkg::REG_CAL_REF_GAIN: cal_ref_gain_q = value;
         cti_pkg::REG_CAL_REF_OFFSET: cal_ref_offset_q = value;
         default: ;
      endcase
   endtask

   always @(negedge clock) begin : drive_beats
      if (!reset && beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
         start <= 1'b1;
         req_payload <= beats_to_send[0];
      end else begin
         start <= 1'b0;
      end
   end

   // response beat is checked before the request beat of the same edge is recorded
   always @(posedge clock) begin : watch_beats
      cti_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (centrality_due.size() == 0) begin
               want = '0;
               report_mismatch("unexpected beat", want);
            end else begin
               want = centrality_due.pop_front();
               if (rsp_payload.result_value !== want.result_value ||
                   rsp_payload.status !== want.status)
                  report_mismatch("mismatch", want);
            end
         end
         if (start && !busy) begin
            centrality_due.push_back(centrality_of(req_payload));
            void'(beats_to_send.pop_front());
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("calibrated_table_interpolator_top_tb: errors");
         $finish;
      end
   end

   initial begin : run
      int ph, k, nload, nbins, cur_edge, cur_val, lo_edge, base, top, pick;
      for (k = 0; k < cti_pkg::MAX_BINS; k++) begin
         edge_tab[k] = '0;
         level_tab[k] = '0;
      end
      bins_in_use = '0;
      cross_section_q = '0;
      cal_gain_q = cti_pkg::Q_ONE;
      cal_offset_q = '0;
      cal_ref_gain_q = cti_pkg::Q_ONE;
      cal_ref_offset_q = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // empty table
      send_query(0, 1'b0);
      send_load(0, q16(1), q16(10));
      send_query(32'sh0000_8000, 1'b0);
      wait_idle();
      write_reg(cti_pkg::REG_BIN_COUNT, 4);
      write_reg(cti_pkg::REG_CROSS_SECTION, 32'h1234_5678);
      send_load(1, q16(3), q16(40));
      send_load(2, q16(8), 0);
      send_load(3, cti_pkg::S32_MAX, cti_pkg::S32_MAX);
      send_query(32'sh0000_8000, 1'b0);
      send_query(cti_pkg::S32_MIN, 1'b0);
      send_query(q16(2), 1'b0);
      send_query(q16(3), 1'b0);
      send_query(q16(5), 1'b0);
      send_query(cti_pkg::S32_MAX, 1'b0);
      send_load(15, -1, -1);
      send_query(q16(1), 1'b1);
      // zero first edge reads as no table
      send_load(0, 0, q16(5));
      send_query(q16(1), 1'b0);
      // negative first edge
      send_load(0, cti_pkg::S32_MIN, cti_pkg::S32_MAX);
      send_query(cti_pkg::S32_MIN, 1'b0);
      send_query(0, 1'b1);
      wait_idle();
      write_reg(cti_pkg::REG_BIN_COUNT, 31);
      write_reg(cti_pkg::REG_CAL_GAIN, cti_pkg::S32_MIN);
      write_reg(cti_pkg::REG_CAL_OFFSET, cti_pkg::S32_MAX);
      write_reg(cti_pkg::REG_CAL_REF_GAIN, 0);
      write_reg(cti_pkg::REG_CAL_REF_OFFSET, cti_pkg::S32_MIN);
      send_query(cti_pkg::S32_MAX, 1'b1);
      send_query(cti_pkg::S32_MIN, 1'b1);
      send_query(cti_pkg::S32_MAX, 1'b0);
      wait_idle();

      for (ph = 0; ph < 9; ph++) begin
         sender_idle_pct = (ph < 3) ? 36 : ((ph < 6) ? 60 : 0);
         nload = (ph == 1) ? 1
               : ((ph >= 7) ? cti_pkg::MAX_BINS : $urandom_range(2, cti_pkg::MAX_BINS - 1));
         nbins = (ph == 7) ? 31 : nload;
         write_reg(cti_pkg::REG_BIN_COUNT, nbins);
         write_reg(cti_pkg::REG_CROSS_SECTION, $urandom);
         if (ph == 8) begin
            write_reg(cti_pkg::REG_CAL_GAIN, cti_pkg::S32_MAX);
            write_reg(cti_pkg::REG_CAL_OFFSET, cti_pkg::S32_MIN);
            write_reg(cti_pkg::REG_CAL_REF_GAIN, cti_pkg::S32_MIN);
            write_reg(cti_pkg::REG_CAL_REF_OFFSET, cti_pkg::S32_MAX);
         end else if (ph % 3 == 2) begin
            write_reg(cti_pkg::REG_CAL_GAIN, $urandom);
            write_reg(cti_pkg::REG_CAL_OFFSET, $urandom);
            write_reg(cti_pkg::REG_CAL_REF_GAIN, (ph == 5) ? 0 : $urandom);
            write_reg(cti_pkg::REG_CAL_REF_OFFSET, $urandom);
         end else begin
            // gains near one, offsets within a few units
            write_reg(cti_pkg::REG_CAL_GAIN, 32768 + $urandom_range(0, 98304));
            write_reg(cti_pkg::REG_CAL_OFFSET, int'($urandom_range(0, 1 << 19)) - (1 << 18));
            write_reg(cti_pkg::REG_CAL_REF_GAIN,
                      (ph == 4) ? 0 : 32768 + $urandom_range(0, 98304));
            write_reg(cti_pkg::REG_CAL_REF_OFFSET,
                      int'($urandom_range(0, 1 << 19)) - (1 << 18));
         end

         // ascending table with random content
         lo_edge = int'($urandom_range(1, SPREAD));
         if ($urandom_range(0, 3) == 0) lo_edge = -lo_edge;
         cur_edge = lo_edge;
         cur_val = $urandom_range(1, 1 << 22);
         for (k = 0; k < nload; k++) begin
            if (k > 0) begin
               cur_edge += $urandom_range(1, SPREAD);
               cur_val += $urandom_range(0, 1 << 22);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) send_load(4'(k), cur_edge, -int'($urandom_range(0, SPREAD)));
            else if (pick == 1) send_load(4'(k), cur_edge, $urandom);
            else send_load(4'(k), cur_edge, cur_val);
         end

         base = ((lo_edge < 0) ? lo_edge : 0) - SPREAD;
         top = cur_edge + SPREAD;
         for (k = 0; k < 70 - nload; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send_load(4'($urandom), $urandom, $urandom);
            else if (pick <= 3) send_query($urandom, 1'($urandom));
            else send_query(base + int'($urandom_range(0, top - base)), 1'($urandom));
         end
         wait_idle();
      end

      repeat (200) @(negedge clock);
      if (mismatches == 0 && centrality_due.size() == 0)
         $display("calibrated_table_interpolator_top_tb: clean");
      else
         $display("calibrated_table_interpolator_top_tb: errors");
      $finish;
   end

endmodule
